// File: rtl/dprq_pkg.sv
// ----------------------------------------------------------------------------
// dprq_pkg
// shared types and constants for the dynamic priority ready queue
// ----------------------------------------------------------------------------
package dprq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // input kind carried in tuser
    localparam logic ACT_ADMIT    = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    // result status carried in tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] need;
        logic [15:0] used;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_DONE
    } t_state;

endpackage

// File: rtl/dynamic_priority_ready_queue_core.sv
// ----------------------------------------------------------------------------
// dynamic_priority_ready_queue_core
// priority ready queue with admit and time-slice dispatch
// ----------------------------------------------------------------------------
// sequence: an accepted transaction goes from idle to the insert state, which walks
// the new entry up one slot per compare, then to the done state, which registers
// the result; full-queue admits and empty-queue or retiring dispatches go straight
// to done. The input is ready only when idle, so no transaction is taken before the
// last result is registered, and a result the receiver holds back stalls the sequencer in its result state.
// reset: synchronous active-low reset empties the queue and drops any result.
// ----------------------------------------------------------------------------
module dynamic_priority_ready_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // proc_id[7:0], priority_req[15:8], need_time[31:16]
    input  logic [0:0]  i_s_tuser,   // action[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // run_id[7:0], run_priority[15:8], run_used[31:16],
                                     // finished[32], queue_count[37:33], zero pad[39:38]
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    // sequencer state
    dprq_pkg::t_state r_state;
    dprq_pkg::t_state n_state;

    // queue row, slot 0 is the head; payload only, no reset
    dprq_pkg::t_entry r_slot [dprq_pkg::QUEUE_DEPTH];
    logic [dprq_pkg::CNT_W-1:0] r_count;

    // entry being walked into place and its current slot
    dprq_pkg::t_entry r_new;
    logic [dprq_pkg::IDX_W-1:0] r_pos;

    // pending result fields
    logic [1:0]  r_res_status;
    logic [7:0]  r_res_id;
    logic [7:0]  r_res_prio;
    logic [15:0] r_res_used;
    logic        r_res_fin;

    // output register
    logic        r_m_tvalid;
    logic [39:0] r_m_tdata;
    logic [1:0]  r_m_tuser;

    // input handshake
    logic w_in_acc;
    logic w_out_free;

    // head entry view for dispatch
    dprq_pkg::t_entry w_head;
    logic [16:0] w_used_inc;
    logic [15:0] w_used_sat;
    logic        w_retire;
    logic [7:0]  w_prio_dec;

    // shared insertion compare
    logic [dprq_pkg::IDX_W-1:0] w_prev_idx;
    dprq_pkg::t_entry           w_prev;
    logic                       w_move;

    // queue full / empty flags
    logic w_full;
    logic w_empty;

    assign o_s_tready = (r_state == dprq_pkg::S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_tvalid || i_m_tready;

    assign w_full  = (r_count == dprq_pkg::CNT_W'(dprq_pkg::QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    // dispatch: one slice added, saturating (for a nonzero need it never exceeds the need anyway)
    assign w_head     = r_slot[0];
    assign w_used_inc = {1'b0, w_head.used} + 17'd1;
    assign w_used_sat = w_used_inc[16] ? 16'hFFFF : w_used_inc[15:0];
    assign w_retire   = (w_used_sat >= w_head.need);
    assign w_prio_dec = (w_head.prio != 8'd0) ? (w_head.prio - 8'd1) : 8'd0;

    // the walk moves the new entry up one slot while the slot above holds a
    // strictly lower priority, so equal priorities stay first come first served
    assign w_prev_idx = r_pos - dprq_pkg::IDX_W'(1);
    assign w_prev     = r_slot[w_prev_idx];
    assign w_move     = (r_pos != '0) && (w_prev.prio < r_new.prio);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dprq_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_tuser[0] == dprq_pkg::ACT_ADMIT) begin
                        n_state = w_full ? dprq_pkg::S_DONE : dprq_pkg::S_INSERT;
                    end else begin
                        n_state = (w_empty || w_retire) ? dprq_pkg::S_DONE
                                                        : dprq_pkg::S_INSERT;
                    end
                end
            end
            dprq_pkg::S_INSERT: begin
                if (!w_move) begin
                    n_state = dprq_pkg::S_DONE;
                end
            end
            dprq_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = dprq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dprq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dprq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // queue count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_state == dprq_pkg::S_IDLE && w_in_acc
                && i_s_tuser[0] == dprq_pkg::ACT_DISPATCH && !w_empty) begin
                r_count <= r_count - dprq_pkg::CNT_W'(1);
            end else if (r_state == dprq_pkg::S_INSERT && !w_move) begin
                r_count <= r_count + dprq_pkg::CNT_W'(1);
            end

            if (r_state == dprq_pkg::S_DONE && w_out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // row, walker and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            dprq_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_res_status <= dprq_pkg::ST_OK;
                    r_res_id     <= 8'd0;
                    r_res_prio   <= 8'd0;
                    r_res_used   <= 16'd0;
                    r_res_fin    <= 1'b0;
                    if (i_s_tuser[0] == dprq_pkg::ACT_ADMIT) begin
                        if (w_full) begin
                            r_res_status <= dprq_pkg::ST_FULL;
                        end
                        r_new.id   <= i_s_tdata[7:0];
                        r_new.prio <= i_s_tdata[15:8];
                        r_new.need <= i_s_tdata[31:16];
                        r_new.used <= 16'd0;
                        r_pos      <= dprq_pkg::IDX_W'(r_count);
                    end else if (w_empty) begin
                        r_res_status <= dprq_pkg::ST_EMPTY;
                    end else begin
                        // pop the head: the whole row moves up one slot
                        for (int k = 0; k < dprq_pkg::QUEUE_DEPTH - 1; k++) begin
                            r_slot[k] <= r_slot[k+1];
                        end
                        r_res_id   <= w_head.id;
                        r_res_used <= w_used_sat;
                        r_res_fin  <= w_retire;
                        r_res_prio <= w_retire ? w_head.prio : w_prio_dec;
                        r_new.id   <= w_head.id;
                        r_new.prio <= w_prio_dec;
                        r_new.need <= w_head.need;
                        r_new.used <= w_used_sat;
                        r_pos      <= dprq_pkg::IDX_W'(r_count - dprq_pkg::CNT_W'(1));
                    end
                end
            end
            dprq_pkg::S_INSERT: begin
                if (w_move) begin
                    r_slot[r_pos] <= w_prev;
                    r_pos         <= w_prev_idx;
                end else begin
                    r_slot[r_pos] <= r_new;
                end
            end
            dprq_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_m_tuser <= r_res_status;
                    r_m_tdata <= {2'b00, 5'(r_count), r_res_fin, r_res_used,
                                  r_res_prio, r_res_id};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

`ifndef SYNTH
    // the count never passes the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dprq_pkg::CNT_W'(dprq_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // an accepted transaction always leaves idle on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state != dprq_pkg::S_IDLE)
        else $error("sequencer stayed idle after accept");

    // the walker never sits below the first free slot
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dprq_pkg::S_INSERT |-> {1'b0, r_pos} <= {1'b0, r_count})
        else $error("insertion walker out of range");

    // a dropped admit reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == dprq_pkg::ST_FULL)
        |-> o_m_tdata[37:33] == 5'(dprq_pkg::QUEUE_DEPTH))
        else $error("full status with queue not full");
`endif

endmodule

// File: dv/dprq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprq_checker
// watches both stream channels of the ready queue, keeps its own copy of the
// queue, predicts each result and compares it with the one that comes out
// ----------------------------------------------------------------------------
module dprq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // proc_id[7:0], priority_req[15:8], need_time[31:16]
    input  logic [0:0]  i_s_tuser,   // action[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // run_id[7:0], run_priority[15:8], run_used[31:16],
                                     // finished[32], queue_count[37:33], zero pad[39:38]
    input  logic [1:0]  i_m_tuser,   // status[1:0]
    output int          o_fail_count,
    output int          o_pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  run_id;
        logic [7:0]  run_prio;
        logic [15:0] run_used;
        logic        finished;
        logic [4:0]  queue_count;
        logic [1:0]  pad;
    } t_slice;

    dprq_pkg::t_entry ready_row [dprq_pkg::QUEUE_DEPTH];
    int               ready_cnt;
    t_slice           slice_q [$];

    // place behind every entry of equal or higher priority
    function automatic void enqueue_ready(dprq_pkg::t_entry e);
        int pos;
        int k;
        pos = 0;
        while (pos < ready_cnt && ready_row[pos].prio >= e.prio)
            pos++;
        for (k = ready_cnt; k > pos; k--)
            ready_row[k] = ready_row[k - 1];
        ready_row[pos] = e;
        ready_cnt++;
    endfunction

    function automatic t_slice schedule_step(logic action, dprq_pkg::t_entry req);
        t_slice           r;
        dprq_pkg::t_entry head;
        int               k;
        r = '0;
        r.status = dprq_pkg::ST_OK;
        if (action == dprq_pkg::ACT_ADMIT) begin
            if (ready_cnt >= dprq_pkg::QUEUE_DEPTH)
                r.status = dprq_pkg::ST_FULL;
            else
                enqueue_ready(req);
        end else if (ready_cnt == 0) begin
            r.status = dprq_pkg::ST_EMPTY;
        end else begin
            head = ready_row[0];
            for (k = 1; k < ready_cnt; k++)
                ready_row[k - 1] = ready_row[k];
            ready_cnt--;
            if (head.used != 16'hFFFF)
                head.used = head.used + 16'd1;
            if (head.used >= head.need) begin
                // retiring entry keeps its priority in the report
                r.finished = 1'b1;
            end else begin
                if (head.prio != 8'd0)
                    head.prio = head.prio - 8'd1;
                enqueue_ready(head);
            end
            r.run_id   = head.id;
            r.run_prio = head.prio;
            r.run_used = head.used;
        end
        r.queue_count = 5'(ready_cnt);
        return r;
    endfunction

    // one line for the expected and one for the actual result
    task automatic report_mismatch(t_slice want, t_slice got);
        $display("mismatch at %0t", $realtime);
        $display("  exp st=%0d id=%0d prio=%0d used=%0d fin=%0d cnt=%0d pad=%0d",
                 want.status, want.run_id, want.run_prio, want.run_used,
                 want.finished, want.queue_count, want.pad);
        $display("  got st=%0d id=%0d prio=%0d used=%0d fin=%0d cnt=%0d pad=%0d",
                 got.status, got.run_id, got.run_prio, got.run_used,
                 got.finished, got.queue_count, got.pad);
    endtask

    always @(posedge i_clk) begin : monitor
        dprq_pkg::t_entry req;
        t_slice           got;
        t_slice           want;
        if (!i_rst_n) begin
            ready_cnt    = 0;
            o_fail_count = 0;
            slice_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                req.id   = i_s_tdata[7:0];
                req.prio = i_s_tdata[15:8];
                req.need = i_s_tdata[31:16];
                req.used = '0;
                slice_q.push_back(schedule_step(i_s_tuser[0], req));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status      = i_m_tuser;
                got.run_id      = i_m_tdata[7:0];
                got.run_prio    = i_m_tdata[15:8];
                got.run_used    = i_m_tdata[31:16];
                got.finished    = i_m_tdata[32];
                got.queue_count = i_m_tdata[37:33];
                got.pad         = i_m_tdata[39:38];
                if (slice_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("unexpected result at %0t: status=%0d id=%0d count=%0d",
                                 $realtime, got.status, got.run_id, got.queue_count);
                end else begin
                    want = slice_q.pop_front();
                    if (got != want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX)
                            report_mismatch(want, got);
                    end
                end
            end
        end
        o_pending = slice_q.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the dynamic priority ready queue: a directed pass
// over empty, full, tie and saturation cases, then random admit and dispatch
// traffic with random idling on both sides and a long output hold-off
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_AT      = 600;   // transactions sent before the long hold-off
    localparam int HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // proc_id[7:0], priority_req[15:8], need_time[31:16]
    logic [0:0]  s_tuser;   // action[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // run_id[7:0], run_priority[15:8], run_used[31:16],
                            // finished[32], queue_count[37:33], zero pad[39:38]
    logic [1:0]  m_tuser;   // status[1:0]

    int fail_count;
    int pending;
    int sent_cnt;
    int cycle_cnt;
    bit src_burst;          // sender offers back to back when set
    bit snk_burst;          // receiver draws no ready gaps when set
    bit sink_hold;          // long receiver hold-off in progress

    dynamic_priority_ready_queue_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    dprq_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns period
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit counted in cycles
    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    // receiver: random ready gaps per result, none in burst phases,
    // and held low throughout the long hold-off
    initial begin : result_sink
        int ready_gap;
        m_tready  = 1'b0;
        ready_gap = $urandom_range(0, 6);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                ready_gap = snk_burst ? 0 : $urandom_range(0, 6);
            @(negedge clk);
            if (sink_hold) begin
                m_tready = 1'b0;
            end else if (ready_gap > 0) begin
                m_tready = 1'b0;
                ready_gap--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // long hold-off once traffic is under way; the sender keeps offering,
    // so the block fills its output and stops taking input
    initial begin : sink_holdoff
        sink_hold = 1'b0;
        wait (sent_cnt >= HOLD_AT);
        @(negedge clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold = 1'b0;
    end

    // offer one transaction after a random gap (none in burst phases); called and returns at a falling edge
    task automatic send_slot_request(logic act, logic [7:0] id, logic [7:0] prio,
                                     logic [15:0] need);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {need, prio, id};
        s_tuser  = act;
        do @(posedge clk); while (!s_tready);
        sent_cnt++;
        @(negedge clk);
    endtask

    task automatic admit(logic [7:0] id, logic [7:0] prio, logic [15:0] need);
        send_slot_request(dprq_pkg::ACT_ADMIT, id, prio, need);
    endtask

    // admit-only fields carry noise on a dispatch
    task automatic dispatch();
        send_slot_request(dprq_pkg::ACT_DISPATCH, 8'($urandom), 8'($urandom),
                          16'($urandom));
    endtask

    initial begin : stimulus
        int       admit_pct;
        int       phase_len;
        int       big_left;
        bit       narrow_prio;
        logic     act;
        logic [15:0] need;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = dprq_pkg::ACT_ADMIT;
        sent_cnt  = 0;
        src_burst = 1'b0;
        snk_burst = 1'b0;
        big_left  = 8;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // dispatch on an empty queue, admit fields all ones
        send_slot_request(dprq_pkg::ACT_DISPATCH, 8'hFF, 8'hFF, 16'hFFFF);
        // two lowest-priority entries: first retires after one slice,
        // second shows priority saturation at zero
        admit(8'h00, 8'h00, 16'd1);
        admit(8'hFF, 8'h00, 16'd3);
        dispatch();
        dispatch();
        // top priority ties, served first come first served
        admit(8'h5A, 8'hFF, 16'hFFFF);
        admit(8'hA5, 8'hFF, 16'd2);
        dispatch();
        dispatch();
        // fill up and overflow with one admit
        repeat (dprq_pkg::QUEUE_DEPTH - 2)
            admit(8'($urandom), 8'($urandom), 16'($urandom_range(1, 8)));
        dispatch();

        // sender pause until every result is back
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);

        // --- random part in phases of varying mix and pacing ---
        while (sent_cnt < RANDOM_ITEMS + 24) begin
            admit_pct   = $urandom_range(25, 75);
            narrow_prio = ($urandom_range(0, 1) == 1);
            src_burst   = ($urandom_range(0, 3) == 0);
            snk_burst   = ($urandom_range(0, 3) == 0);
            phase_len   = $urandom_range(40, 120);
            repeat (phase_len) begin
                act = ($urandom_range(0, 99) < admit_pct) ? dprq_pkg::ACT_ADMIT
                                                          : dprq_pkg::ACT_DISPATCH;
                // long needs are rare so the queue keeps draining
                if (big_left > 0 && $urandom_range(0, 99) == 0) begin
                    need = 16'($urandom_range(1, 65535));
                    big_left--;
                end else begin
                    need = 16'($urandom_range(1, 8));
                end
                if (act == dprq_pkg::ACT_ADMIT)
                    admit(8'($urandom),
                          narrow_prio ? 8'($urandom_range(0, 3)) : 8'($urandom), need);
                else
                    dispatch();
            end
        end

        // drain
        s_tvalid  = 1'b0;
        src_burst = 1'b0;
        snk_burst = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (dprq_pkg::QUEUE_DEPTH + 8) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dprq_pkg.sv
rtl/dynamic_priority_ready_queue_core.sv
dv/dprq_checker.sv
dv/tb_top.sv
